[src/swa_pkg.sv]
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types, constants and helpers for the sliding-window ARQ sender.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int SEQ_W   = 3;
    localparam int SEQ_NUM = 8;   // 2**SEQ_W
    localparam int WINDOW  = 4;
    localparam int CNT_W   = 3;   // holds 0..WINDOW
    localparam int TMR_W   = 8;
    localparam int LIM_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int QDEPTH  = 2;

    localparam logic [TMR_W-1:0] TIMEOUT_RST = 8'd6;
    localparam logic [LIM_W-1:0] LIMIT_RST   = 16'd14;

    typedef enum logic [1:0] {
        CMD_TSTART = 2'd0,
        CMD_ACK    = 2'd1,
        CMD_NAK    = 2'd2,
        CMD_TEND   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_MODE    = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_LIMIT   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_NEW     = 2'd0,
        KIND_TIMEOUT = 2'd1,
        KIND_NAK     = 2'd2
    } kind_t;

    typedef struct packed {
        logic              mode;
        logic [TMR_W-1:0]  timeout;
        logic [LIM_W-1:0]  limit;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [SEQ_W-1:0]  seq;
    } item_t;

    typedef struct packed {
        logic              send_valid;
        logic [SEQ_W-1:0]  send_seq;
        kind_t             send_kind;
        logic              timeout_seen;
        logic              ack_accepted;
        logic              nak_deferred;
        logic [CNT_W-1:0]  outstanding;
    } res_t;

    // b lies in [a, c) modulo the sequence space
    function automatic logic in_win(input logic [SEQ_W-1:0] a,
                                    input logic [SEQ_W-1:0] b,
                                    input logic [SEQ_W-1:0] c);
        logic [SEQ_W-1:0] db;
        logic [SEQ_W-1:0] dc;
        db = b - a;
        dc = c - a;
        return db < dc;
    endfunction

endpackage

[src/sliding_window_arq_sender_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_arq_sender_unit
// Sender of a sliding-window ARQ link, selectable whole-window or selective resend.
// ----------------------------------------------------------------------------
// Flow: an input beat is queued, popped into the item register and executed; the
//   result is registered; tick end adds a drain state. The engine's sequencer
//   takes one event at a time and starts it only when the result register is empty.
// A two-beat input queue keeps taking beats while a result waits, until it is full.
// Reset: asynchronous, active low; window, timers, list count and config go to
//   their defaults (go-back mode, timeout 6, limit 14).
module sliding_window_arq_sender_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [swa_pkg::IDX_W-1:0]     cfg_index,
    input  logic [swa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic [swa_pkg::SEQ_W-1:0]     frame_seq,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          send_valid,
    output logic [swa_pkg::SEQ_W-1:0]     send_seq,
    output logic [1:0]                    send_kind,
    output logic                          timeout_seen,
    output logic                          ack_accepted,
    output logic                          nak_deferred,
    output logic [swa_pkg::CNT_W-1:0]     outstanding
);

    swa_pkg::cfg_t  cfg_reg, cfg_next;
    logic           q_valid;
    swa_pkg::item_t q_item;
    logic           q_pop;
    swa_pkg::res_t  res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                swa_pkg::CFG_MODE:    cfg_next.mode    = cfg_data[0];
                swa_pkg::CFG_TIMEOUT: cfg_next.timeout = cfg_data[swa_pkg::TMR_W-1:0];
                swa_pkg::CFG_LIMIT:   cfg_next.limit   = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode    <= 1'b0;
            cfg_reg.timeout <= swa_pkg::TIMEOUT_RST;
            cfg_reg.limit   <= swa_pkg::LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    swa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .frame_seq (frame_seq),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    swa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign send_valid   = res.send_valid;
    assign send_seq     = res.send_seq;
    assign send_kind    = res.send_kind;
    assign timeout_seen = res.timeout_seen;
    assign ack_accepted = res.ack_accepted;
    assign nak_deferred = res.nak_deferred;
    assign outstanding  = res.outstanding;

    a_outst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outstanding <= 3'(swa_pkg::WINDOW)))
        else $error("outstanding beyond window");

    a_idle_send: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !send_valid) |-> (send_seq == '0 && send_kind == swa_pkg::KIND_NEW))
        else $error("send fields set without a send");

    a_ack_nosend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(ack_accepted && send_valid) && !(nak_deferred && send_valid))
        else $error("ack or deferred nak with a send");

    a_timeout_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && send_valid && send_kind == swa_pkg::KIND_NEW) |-> !nak_deferred)
        else $error("new frame on a nak beat");

endmodule

[src/swa_front.sv]
// ----------------------------------------------------------------------------
// swa_front
// Input side: takes event beats, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module swa_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [swa_pkg::SEQ_W-1:0] frame_seq,
    output logic                    q_valid,
    output swa_pkg::item_t          q_item,
    input  logic                    q_pop
);

    swa_pkg::item_t q_reg [swa_pkg::QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    logic           pop;
    swa_pkg::item_t dec;

    always_comb
    begin
        dec.cmd = swa_pkg::cmd_t'(cmd);
        dec.seq = frame_seq;
    end

    assign in_stall = (cnt_reg == 2'(swa_pkg::QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[src/swa_back.sv]
// ----------------------------------------------------------------------------
// swa_back
// Protocol engine: window, timers, retransmit list and the result register.
// ----------------------------------------------------------------------------
module swa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  swa_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  swa_pkg::item_t  q_item,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output swa_pkg::res_t   res
);

    localparam int SW = swa_pkg::SEQ_W;
    localparam int CW = swa_pkg::CNT_W;
    localparam int TW = swa_pkg::TMR_W;
    localparam int NW = swa_pkg::WINDOW;
    localparam int NS = swa_pkg::SEQ_NUM;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    swa_pkg::item_t         item_reg, item_next;
    logic [SW-1:0]          base_reg, base_next;
    logic [swa_pkg::LIM_W-1:0] nsent_reg, nsent_next;
    logic [CW-1:0]          outst_reg, outst_next;
    logic [NS-1:0]          trun_reg, trun_next;
    logic [TW-1:0]          tleft_reg [NS];
    logic [TW-1:0]          tleft_next [NS];
    logic                   sent_reg, sent_next;
    logic [SW-1:0]          list_reg [NW];
    logic [SW-1:0]          list_next [NW];
    logic [CW-1:0]          lcnt_reg, lcnt_next;
    swa_pkg::res_t          res_reg, res_next;
    logic                   ov_reg, ov_next;

    assign out_valid = ov_reg;
    assign res       = res_reg;

    always_comb
    begin
        logic [SW-1:0] nx;
        logic [SW-1:0] k;
        logic [SW-1:0] off;
        logic [NS-1:0] rm;
        logic [CW-1:0] wc;
        logic [NS-1:0] exp_off;
        logic          found;
        logic [1:0]    fo;
        logic [SW-1:0] tgt;
        logic          dup;
        logic [CW-1:0] sh;
        logic [CW-1:0] src;
        logic [SW-1:0] hold [NW];

        state_next = state_reg;
        item_next  = item_reg;
        base_next  = base_reg;
        nsent_next = nsent_reg;
        outst_next = outst_reg;
        trun_next  = trun_reg;
        tleft_next = tleft_reg;
        sent_next  = sent_reg;
        list_next  = list_reg;
        lcnt_next  = lcnt_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && out_stall;
        q_pop      = 1'b0;

        nx      = base_reg + outst_reg;
        k       = '0;
        off     = '0;
        rm      = '0;
        wc      = '0;
        exp_off = '0;
        found   = 1'b0;
        fo      = '0;
        tgt     = '0;
        dup     = 1'b0;
        sh      = '0;
        src     = '0;
        hold    = list_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // start only once the result slot is free
                if (q_valid && !ov_reg)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_next = '0;
                unique case (item_reg.cmd)
                    swa_pkg::CMD_TSTART:
                    begin
                        for (int i = 0; i < NS; i++)
                        begin
                            if (trun_reg[i] && tleft_reg[i] != '0)
                            begin
                                tleft_next[i] = tleft_reg[i] - 1'b1;
                            end
                        end
                        sent_next = 1'b0;
                    end

                    swa_pkg::CMD_ACK:
                    begin
                        if (swa_pkg::in_win(base_reg, item_reg.seq, nx))
                        begin
                            res_next.ack_accepted = 1'b1;
                            k = item_reg.seq - base_reg;
                            for (int i = 0; i < NS; i++)
                            begin
                                off = SW'(i) - base_reg;
                                if (off <= k)
                                begin
                                    rm[i]        = 1'b1;
                                    trun_next[i] = 1'b0;
                                end
                            end
                            // purge acked frames, keep order
                            for (int j = 0; j < NW; j++)
                            begin
                                if (CW'(j) < lcnt_reg && !rm[list_reg[j]])
                                begin
                                    list_next[wc[1:0]] = list_reg[j];
                                    wc = wc + 1'b1;
                                end
                            end
                            lcnt_next  = wc;
                            base_next  = item_reg.seq + 1'b1;
                            outst_next = outst_reg - CW'({1'b0, k} + 4'd1);
                        end
                    end

                    swa_pkg::CMD_NAK:
                    begin
                        if (cfg.mode && swa_pkg::in_win(base_reg, item_reg.seq, nx))
                        begin
                            if (!sent_reg)
                            begin
                                res_next.send_valid     = 1'b1;
                                res_next.send_seq       = item_reg.seq;
                                res_next.send_kind      = swa_pkg::KIND_NAK;
                                trun_next[item_reg.seq] = 1'b1;
                                tleft_next[item_reg.seq] = cfg.timeout;
                                sent_next               = 1'b1;
                            end
                            else
                            begin
                                res_next.nak_deferred = 1'b1;
                            end
                        end
                    end

                    default:
                    begin
                        // tick end, first half: timeout scan in window order
                        for (int i = 0; i < NS; i++)
                        begin
                            off = SW'(i) - base_reg;
                            if ({1'b0, off} < {1'b0, outst_reg} && trun_reg[i]
                                && tleft_reg[i] == '0)
                            begin
                                exp_off[off] = 1'b1;
                            end
                        end
                        for (int j = NW - 1; j >= 0; j--)
                        begin
                            if (exp_off[j])
                            begin
                                found = 1'b1;
                                fo    = 2'(j);
                            end
                        end
                        if (found)
                        begin
                            res_next.timeout_seen = 1'b1;
                            if (!cfg.mode)
                            begin
                                wc = lcnt_reg;
                                for (int j = 0; j < NW; j++)
                                begin
                                    if (CW'(j) < outst_reg)
                                    begin
                                        tgt = base_reg + SW'(j);
                                        trun_next[tgt] = 1'b0;
                                        dup = 1'b0;
                                        for (int m = 0; m < NW; m++)
                                        begin
                                            if (CW'(m) < wc && hold[m] == tgt)
                                            begin
                                                dup = 1'b1;
                                            end
                                        end
                                        if (!dup && wc < CW'(NW))
                                        begin
                                            hold[wc[1:0]] = tgt;
                                            wc = wc + 1'b1;
                                        end
                                    end
                                end
                                list_next = hold;
                                lcnt_next = wc;
                            end
                            else if (!sent_reg)
                            begin
                                tgt = base_reg + SW'(fo);
                                res_next.send_valid = 1'b1;
                                res_next.send_seq   = tgt;
                                res_next.send_kind  = swa_pkg::KIND_TIMEOUT;
                                tleft_next[tgt]     = cfg.timeout;
                                sent_next           = 1'b1;
                            end
                        end
                    end
                endcase

                if (item_reg.cmd == swa_pkg::CMD_TEND)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    res_next.outstanding = outst_next;
                    ov_next              = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                // tick end, second half: drain retransmit list, then new frame
                for (int j = NW - 1; j >= 0; j--)
                begin
                    if (CW'(j) < lcnt_reg && swa_pkg::in_win(base_reg, list_reg[j], nx))
                    begin
                        found = 1'b1;
                        fo    = 2'(j);
                    end
                end
                if (!found)
                begin
                    lcnt_next = '0;
                end
                else
                begin
                    if (sent_reg)
                    begin
                        sh = CW'(fo);
                    end
                    else
                    begin
                        sh  = CW'(fo) + 1'b1;
                        tgt = list_reg[fo];
                        res_next.send_valid = 1'b1;
                        res_next.send_seq   = tgt;
                        res_next.send_kind  = swa_pkg::KIND_TIMEOUT;
                        trun_next[tgt]      = 1'b1;
                        tleft_next[tgt]     = cfg.timeout;
                        sent_next           = 1'b1;
                    end
                    for (int j = 0; j < NW; j++)
                    begin
                        src = CW'(j) + sh;
                        if (src < CW'(NW))
                        begin
                            list_next[j] = list_reg[src[1:0]];
                        end
                    end
                    lcnt_next = lcnt_reg - sh;
                end

                if (lcnt_next == '0 && !sent_next && outst_reg < CW'(NW)
                    && nsent_reg < cfg.limit)
                begin
                    res_next.send_valid = 1'b1;
                    res_next.send_seq   = nx;
                    res_next.send_kind  = swa_pkg::KIND_NEW;
                    trun_next[nx]       = 1'b1;
                    tleft_next[nx]      = cfg.timeout;
                    nsent_next          = nsent_reg + 1'b1;
                    outst_next          = outst_reg + 1'b1;
                    sent_next           = 1'b1;
                end
                res_next.outstanding = outst_next;
                ov_next              = 1'b1;
                state_next           = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            nsent_reg <= '0;
            outst_reg <= '0;
            trun_reg  <= '0;
            sent_reg  <= 1'b0;
            lcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NS; i++)
            begin
                tleft_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            nsent_reg <= nsent_next;
            outst_reg <= outst_next;
            trun_reg  <= trun_next;
            sent_reg  <= sent_next;
            lcnt_reg  <= lcnt_next;
            ov_reg    <= ov_next;
            tleft_reg <= tleft_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        list_reg <= list_next;
        res_reg  <= res_next;
    end

endmodule
